// ----- rtl/core/hcbb_pkg.sv -----
package hcbb_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MIN_COUNT  = 20;

  localparam int CHAN_W     = 8;
  localparam int NUM_W      = 17;
  localparam int FRAC_W     = 8;
  localparam int DIVIDEND_W = NUM_W + FRAC_W;
  localparam int HUE_W      = 17;
  localparam int QUO_W      = 18;
  localparam int DIV_STEPS  = QUO_W / 2;
  localparam int STEP_W     = 4;

  typedef enum logic [2:0] {
    REG_HUE_LOW      = 3'd0,
    REG_HUE_HIGH     = 3'd1,
    REG_SAT_LOW      = 3'd2,
    REG_SAT_HIGH     = 3'd3,
    REG_VAL_LOW      = 3'd4,
    REG_VAL_HIGH     = 3'd5,
    REG_FRAME_WIDTH  = 3'd6,
    REG_FRAME_HEIGHT = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    BASE_0   = 2'd0,
    BASE_120 = 2'd1,
    BASE_240 = 2'd2,
    BASE_360 = 2'd3
  } hue_base_t;

  function automatic logic [8:0] hue_base_deg(input hue_base_t base);
    logic [8:0] deg;
    unique case (base)
      BASE_0:   deg = 9'd0;
      BASE_120: deg = 9'd120;
      BASE_240: deg = 9'd240;
      BASE_360: deg = 9'd360;
      default:  deg = 9'd0;
    endcase
    return deg;
  endfunction

endpackage

// ----- rtl/core/hcbb_hue_div.sv -----
module hcbb_hue_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [hcbb_pkg::DIVIDEND_W-1:0]  dividend,
  input  logic [hcbb_pkg::CHAN_W-1:0]      divisor,
  output logic                             done,
  output logic [hcbb_pkg::HUE_W-1:0]       quotient
);
  import hcbb_pkg::*;

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [CHAN_W-1:0] rem;
  logic [QUO_W-1:0]  acc;

  logic [CHAN_W:0]   r1, r1s, r2, r2s;
  logic              ge1, ge2;

  // Two restoring steps per cycle, quotient bits shift in behind the dividend.
  always_comb begin
    r1  = {rem, acc[QUO_W-1]};
    ge1 = r1 >= {1'b0, divisor};
    r1s = ge1 ? r1 - {1'b0, divisor} : r1;
    r2  = {r1s[CHAN_W-1:0], acc[QUO_W-2]};
    ge2 = r2 >= {1'b0, divisor};
    r2s = ge2 ? r2 - {1'b0, divisor} : r2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= busy && (steps == STEP_W'(1));
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DIV_STEPS);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {1'b0, dividend[DIVIDEND_W-1:QUO_W]};
      acc <= dividend[QUO_W-1:0];
    end else if (busy) begin
      rem <= r2s[CHAN_W-1:0];
      acc <= {acc[QUO_W-3:0], ge1, ge2};
    end
  end

  assign quotient = acc[HUE_W-1:0];

endmodule

// ----- rtl/core/hsv_color_blob_box.sv -----
// An accepted pixel request passes through the range and numerator steps, a divide step in
// which the serial hue divider resolves two quotient bits per cycle, then the update and
// final steps.
// s_tready is high only in the idle step, so no new pixel is taken until the last result leaves the final step.
// A result waiting on m_tready holds the block in its final step.
// Synchronous reset restores the default thresholds and frame size and starts a new frame.
module hsv_color_blob_box (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // pixel_blue, pixel_green, pixel_red
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // mask_on, box_left, box_top, box_width, box_height, zero pad
  output logic        m_tlast,
  output logic [0:0]  m_tuser,   // box_valid
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hcbb_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RANGE = 6'b000010,
    S_NUM   = 6'b000100,
    S_DIV   = 6'b001000,
    S_UPD   = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [8:0] hue_low, hue_high, frame_width, frame_height;
  logic [7:0] sat_low, sat_high, val_low, val_high;

  logic [7:0] pix_b, pix_g, pix_r;
  logic [7:0] cmax, diff, delta;
  logic       plus;
  hue_base_t  base;
  logic [NUM_W-1:0] num;
  logic       pre_ok;

  logic [7:0]  column_pos, row_pos, most_column, most_row;
  logic [8:0]  least_column, least_row;
  logic [16:0] match_count;
  logic        mask_q, done_q;

  logic              div_done;
  logic [HUE_W-1:0]  quotient;
  logic              div_busy_seen;

  logic       cfg_write;
  reg_idx_t   reg_idx;
  logic       out_load;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = reg_idx_t'(paddr[4:2]);
  assign s_tready  = (state == S_IDLE);
  assign out_load  = !m_tvalid || m_tready;

  always_comb begin
    unique case (reg_idx)
      REG_HUE_LOW:      prdata = {23'd0, hue_low};
      REG_HUE_HIGH:     prdata = {23'd0, hue_high};
      REG_SAT_LOW:      prdata = {24'd0, sat_low};
      REG_SAT_HIGH:     prdata = {24'd0, sat_high};
      REG_VAL_LOW:      prdata = {24'd0, val_low};
      REG_VAL_HIGH:     prdata = {24'd0, val_high};
      REG_FRAME_WIDTH:  prdata = {23'd0, frame_width};
      REG_FRAME_HEIGHT: prdata = {23'd0, frame_height};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_low      <= 9'd352;
      hue_high     <= 9'd5;
      sat_low      <= 8'd196;
      sat_high     <= 8'd255;
      val_low      <= 8'd88;
      val_high     <= 8'd255;
      frame_width  <= 9'd160;
      frame_height <= 9'd120;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_HUE_LOW:      hue_low      <= pwdata[8:0];
        REG_HUE_HIGH:     hue_high     <= pwdata[8:0];
        REG_SAT_LOW:      sat_low      <= pwdata[7:0];
        REG_SAT_HIGH:     sat_high     <= pwdata[7:0];
        REG_VAL_LOW:      val_low      <= pwdata[7:0];
        REG_VAL_HIGH:     val_high     <= pwdata[7:0];
        REG_FRAME_WIDTH:  frame_width  <= pwdata[8:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[8:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (s_tvalid) state_next = S_RANGE;
      S_RANGE: state_next = S_NUM;
      S_NUM:   state_next = S_DIV;
      S_DIV:   if (div_done) state_next = S_UPD;
      S_UPD:   state_next = S_FIN;
      S_FIN:   if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Range step: largest channel with red, then green, then blue priority.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid) begin
      pix_b <= s_tdata[7:0];
      pix_g <= s_tdata[15:8];
      pix_r <= s_tdata[23:16];
    end
  end

  logic [7:0] cmin_c;
  always_comb begin
    cmin_c = pix_r;
    if (pix_g < cmin_c) cmin_c = pix_g;
    if (pix_b < cmin_c) cmin_c = pix_b;
  end

  always_ff @(posedge clk) begin
    if (state == S_RANGE) begin
      if (pix_r >= pix_g && pix_r >= pix_b) begin
        cmax  <= pix_r;
        diff  <= pix_r - cmin_c;
        plus  <= pix_g >= pix_b;
        base  <= (pix_g >= pix_b) ? BASE_0 : BASE_360;
        delta <= (pix_g >= pix_b) ? pix_g - pix_b : pix_b - pix_g;
      end else if (pix_g >= pix_b) begin
        cmax  <= pix_g;
        diff  <= pix_g - cmin_c;
        plus  <= pix_b >= pix_r;
        base  <= BASE_120;
        delta <= (pix_b >= pix_r) ? pix_b - pix_r : pix_r - pix_b;
      end else begin
        cmax  <= pix_b;
        diff  <= pix_b - cmin_c;
        plus  <= pix_r >= pix_g;
        base  <= BASE_240;
        delta <= (pix_r >= pix_g) ? pix_r - pix_g : pix_g - pix_r;
      end
    end
  end

  // Numerator step, with saturation tested by cross-multiplication.
  logic [NUM_W-1:0] base_term, sixty_term;
  logic [15:0]      diff255, sat_lo_prod, sat_hi_prod;
  logic             sat_ok;

  always_comb begin
    base_term   = NUM_W'(diff) * NUM_W'(hue_base_deg(base));
    sixty_term  = NUM_W'(delta) * NUM_W'(60);
    diff255     = {diff, 8'd0} - {8'd0, diff};
    sat_lo_prod = {8'd0, sat_low} * {8'd0, cmax};
    sat_hi_prod = {8'd0, sat_high} * {8'd0, cmax};
    if (cmax == '0) begin
      sat_ok = (sat_low == '0);
    end else begin
      sat_ok = (diff255 >= sat_lo_prod) && (diff255 <= sat_hi_prod);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_NUM) begin
      num    <= plus ? base_term + sixty_term : base_term - sixty_term;
      pre_ok <= sat_ok && (cmax >= val_low) && (cmax <= val_high);
    end
  end

  hcbb_hue_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_DIV && !div_busy_seen),
    .dividend ({num, FRAC_W'(0)}),
    .divisor  (diff),
    .done     (div_done),
    .quotient (quotient)
  );

  // The divider is launched on entry to the divide step.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy_seen <= 1'b0;
    end else begin
      div_busy_seen <= (state == S_DIV) && !div_done;
    end
  end

  // Update step: hue window, mask and frame bookkeeping.
  logic [HUE_W-1:0] hue;
  logic [HUE_W-1:0] hue_lo_fx, hue_hi_fx;
  logic             hue_ok, mask_now;
  logic [7:0]       col_last, row_last;
  logic             line_end, done_now;

  always_comb begin
    hue       = (diff == '0) ? '0 : quotient;
    hue_lo_fx = {hue_low, FRAC_W'(0)};
    hue_hi_fx = {hue_high, FRAC_W'(0)};
    if (hue_low > hue_high) begin
      hue_ok = (hue >= hue_lo_fx) || (hue <= hue_hi_fx);
    end else begin
      hue_ok = (hue >= hue_lo_fx) && (hue <= hue_hi_fx);
    end
    mask_now = pre_ok && hue_ok;

    if (frame_width == '0) begin
      col_last = '0;
    end else if (frame_width > 9'(MAX_WIDTH)) begin
      col_last = 8'(MAX_WIDTH - 1);
    end else begin
      col_last = 8'(frame_width - 9'd1);
    end
    if (frame_height == '0) begin
      row_last = '0;
    end else if (frame_height > 9'(MAX_HEIGHT)) begin
      row_last = 8'(MAX_HEIGHT - 1);
    end else begin
      row_last = 8'(frame_height - 9'd1);
    end
    line_end = column_pos >= col_last;
    done_now = line_end && (row_pos >= row_last);
  end

  // Final step: box size, area and fill test.
  logic [8:0]  box_w, box_h;
  logic [17:0] area;
  logic [19:0] count5;
  logic        box_ok;

  always_comb begin
    box_w  = {1'b0, most_column} - least_column + 9'd1;
    box_h  = {1'b0, most_row} - least_row + 9'd1;
    area   = 18'(box_w) * 18'(box_h);
    count5 = {1'b0, match_count, 2'b00} + {3'd0, match_count};
    box_ok = done_q && (match_count > 17'(MIN_COUNT)) && (count5 > {2'd0, area});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos   <= '0;
      row_pos      <= '0;
      least_column <= 9'(MAX_WIDTH);
      most_column  <= '0;
      least_row    <= 9'(MAX_HEIGHT);
      most_row     <= '0;
      match_count  <= '0;
      mask_q       <= 1'b0;
      done_q       <= 1'b0;
    end else if (state == S_UPD) begin
      mask_q <= mask_now;
      done_q <= done_now;
      if (mask_now) begin
        if ({1'b0, column_pos} < least_column) least_column <= {1'b0, column_pos};
        if (column_pos > most_column) most_column <= column_pos;
        if ({1'b0, row_pos} < least_row) least_row <= {1'b0, row_pos};
        if (row_pos > most_row) most_row <= row_pos;
        match_count <= match_count + 17'd1;
      end
      if (done_now) begin
        column_pos <= '0;
        row_pos    <= '0;
      end else if (line_end) begin
        column_pos <= '0;
        row_pos    <= row_pos + 8'd1;
      end else begin
        column_pos <= column_pos + 8'd1;
      end
    end else if (state == S_FIN && out_load && done_q) begin
      least_column <= 9'(MAX_WIDTH);
      most_column  <= '0;
      least_row    <= 9'(MAX_HEIGHT);
      most_row     <= '0;
      match_count  <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_FIN && out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_load) begin
      m_tlast    <= done_q;
      m_tuser[0] <= box_ok;
      m_tdata    <= {5'd0,
                     box_ok ? box_h : 9'd0,
                     box_ok ? box_w : 9'd0,
                     box_ok ? least_row[7:0] : 8'd0,
                     box_ok ? least_column[7:0] : 8'd0,
                     mask_q};
    end
  end

  a_box_only_at_frame_end : assert property (
    @(posedge clk) disable iff (rst) (m_tvalid && m_tuser[0]) |-> m_tlast)
    else $error("box reported on a pixel that does not end the frame");

  a_frame_cleared : assert property (
    @(posedge clk) disable iff (rst)
    (state == S_FIN && out_load && done_q) |=> (match_count == '0))
    else $error("match count not cleared after the last pixel of a frame");

  a_div_done_in_div : assert property (
    @(posedge clk) disable iff (rst) div_done |-> (state == S_DIV))
    else $error("divider finished outside the divide step");

endmodule

// ----- tb/hsv_color_blob_box_check.sv -----
module hsv_color_blob_box_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // pixel_blue, pixel_green, pixel_red
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // mask_on, box_left, box_top, box_width, box_height, zero pad
  input  logic        m_tlast,
  input  logic [0:0]  m_tuser,   // box_valid
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          open_results
);
  timeunit 1ns;
  timeprecision 1ps;
  import hcbb_pkg::*;

  typedef struct packed {
    logic       mask_on;
    logic       frame_done;
    logic       box_valid;
    logic [7:0] box_left;
    logic [7:0] box_top;
    logic [8:0] box_width;
    logic [8:0] box_height;
  } pixel_verdict_t;

  logic [8:0] hue_lo, hue_hi, width_cfg, height_cfg;
  logic [7:0] sat_lo, sat_hi, val_lo, val_hi;
  logic [7:0] col, row, max_col, max_row;
  logic [8:0] min_col, min_row;
  logic [16:0] hits;
  pixel_verdict_t pixel_verdicts [$];
  int fails = 0;

  function automatic logic in_window(input logic [7:0] r, input logic [7:0] g,
                                     input logic [7:0] b);
    int unsigned ri, gi, bi, cmax, cmin, diff, num, hue;
    logic sat_ok, hue_ok;
    ri = 32'(r);
    gi = 32'(g);
    bi = 32'(b);
    cmax = ri;
    if (gi > cmax) cmax = gi;
    if (bi > cmax) cmax = bi;
    cmin = ri;
    if (gi < cmin) cmin = gi;
    if (bi < cmin) cmin = bi;
    diff = cmax - cmin;
    if (cmax == 0) sat_ok = (sat_lo == 0);
    else sat_ok = (diff * 255 >= sat_lo * cmax) && (diff * 255 <= sat_hi * cmax);
    if (!sat_ok || cmax < val_lo || cmax > val_hi) return 1'b0;
    num = 0;
    if (diff == 0) num = 0;
    else if (cmax == ri) begin
      if (gi >= bi) num = 60 * (gi - bi);
      else num = 360 * diff - 60 * (bi - gi);
    end else if (cmax == gi) begin
      if (bi >= ri) num = 120 * diff + 60 * (bi - ri);
      else num = 120 * diff - 60 * (ri - bi);
    end else begin
      if (ri >= gi) num = 240 * diff + 60 * (ri - gi);
      else num = 240 * diff - 60 * (gi - ri);
    end
    hue = (diff == 0) ? 0 : (num * 256) / diff;
    if (hue_lo > hue_hi) hue_ok = (hue >= hue_lo * 256) || (hue <= hue_hi * 256);
    else hue_ok = (hue >= hue_lo * 256) && (hue <= hue_hi * 256);
    return hue_ok;
  endfunction

  function automatic pixel_verdict_t track_pixel(input logic [23:0] px);
    int unsigned w, h, bw, bh;
    logic hit, line_end, done;
    pixel_verdict_t res;
    w = (width_cfg == 0) ? 1 : ((width_cfg > MAX_WIDTH) ? MAX_WIDTH : 32'(width_cfg));
    h = (height_cfg == 0) ? 1 : ((height_cfg > MAX_HEIGHT) ? MAX_HEIGHT : 32'(height_cfg));
    hit = in_window(px[23:16], px[15:8], px[7:0]);
    line_end = (col >= w - 1);
    done = line_end && (row >= h - 1);
    res = '0;
    res.mask_on = hit;
    res.frame_done = done;
    if (hit) begin
      if ({1'b0, col} < min_col) min_col = {1'b0, col};
      if (col > max_col) max_col = col;
      if ({1'b0, row} < min_row) min_row = {1'b0, row};
      if (row > max_row) max_row = row;
      hits = hits + 17'd1;
    end
    if (done) begin
      if (hits > MIN_COUNT) begin
        bw = 32'(max_col);
        bw = bw - min_col + 1;
        bh = 32'(max_row);
        bh = bh - min_row + 1;
        if (hits * 5 > bw * bh) begin
          res.box_valid = 1'b1;
          res.box_left = min_col[7:0];
          res.box_top = min_row[7:0];
          res.box_width = bw[8:0];
          res.box_height = bh[8:0];
        end
      end
      min_col = 9'(MAX_WIDTH);
      max_col = '0;
      min_row = 9'(MAX_HEIGHT);
      max_row = '0;
      hits = '0;
      col = '0;
      row = '0;
    end else if (line_end) begin
      col = '0;
      row = row + 8'd1;
    end else begin
      col = col + 8'd1;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    pixel_verdict_t got, want;
    if (rst) begin
      hue_lo = 9'd352;
      hue_hi = 9'd5;
      sat_lo = 8'd196;
      sat_hi = 8'd255;
      val_lo = 8'd88;
      val_hi = 8'd255;
      width_cfg = 9'd160;
      height_cfg = 9'd120;
      col = '0;
      row = '0;
      min_col = 9'(MAX_WIDTH);
      max_col = '0;
      min_row = 9'(MAX_HEIGHT);
      max_row = '0;
      hits = '0;
      pixel_verdicts.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_HUE_LOW:      hue_lo = pwdata[8:0];
          REG_HUE_HIGH:     hue_hi = pwdata[8:0];
          REG_SAT_LOW:      sat_lo = pwdata[7:0];
          REG_SAT_HIGH:     sat_hi = pwdata[7:0];
          REG_VAL_LOW:      val_lo = pwdata[7:0];
          REG_VAL_HIGH:     val_hi = pwdata[7:0];
          REG_FRAME_WIDTH:  width_cfg = pwdata[8:0];
          REG_FRAME_HEIGHT: height_cfg = pwdata[8:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) pixel_verdicts.push_back(track_pixel(s_tdata));
      if (m_tvalid && m_tready) begin
        got.mask_on = m_tdata[0];
        got.frame_done = m_tlast;
        got.box_valid = m_tuser[0];
        got.box_left = m_tdata[8:1];
        got.box_top = m_tdata[16:9];
        got.box_width = m_tdata[25:17];
        got.box_height = m_tdata[34:26];
        if (pixel_verdicts.size() == 0) begin
          fails++;
          if (fails <= 10) $display("%0t: result with no pixel request pending", $time);
        end else begin
          want = pixel_verdicts.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10)
              $display("%0t: mismatch, expected mask %0d done %0d valid %0d box %0d,%0d %0dx%0d,",
                       $time, want.mask_on, want.frame_done, want.box_valid, want.box_left,
                       want.box_top, want.box_width, want.box_height,
                       " got mask %0d done %0d valid %0d box %0d,%0d %0dx%0d",
                       got.mask_on, got.frame_done, got.box_valid, got.box_left,
                       got.box_top, got.box_width, got.box_height);
          end
        end
      end
    end
    fail_count <= fails;
    open_results <= pixel_verdicts.size();
  end

endmodule

// ----- tb/hsv_color_blob_box_tb.sv -----
module hsv_color_blob_box_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hcbb_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int TOTAL_PIXELS = 1550;
  localparam logic [23:0] PROBE_COLOURS [0:22] = '{
    24'hFF0000, 24'h000000, 24'hFFFFFF, 24'h808080, 24'h00FF00, 24'h0000FF,
    24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hFF0010, 24'hFF0030, 24'hFF0500,
    24'hFF1600, 24'hFF1500, 24'h580000, 24'h570000, 24'hFF3C3C, 24'hFF3B3B,
    24'h010000, 24'h00FF01, 24'h01FF00, 24'h7F00FF, 24'hAA5500
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;
  logic [0:0]  m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          open_results;
  int          cycles = 0;
  int          sent = 0;
  bit          calm = 1'b0;

  hsv_color_blob_box dut (.*);

  hsv_color_blob_box_check box_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .open_results(open_results)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : receiver
    int stall;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  task automatic send_pixel(input logic [23:0] px);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= px;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (open_results != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_windows(input int hl, input int hh, input int sl, input int sh,
                             input int vl, input int vh, input int fw, input int fh);
    write_reg(REG_HUE_LOW, hl);
    write_reg(REG_HUE_HIGH, hh);
    write_reg(REG_SAT_LOW, sl);
    write_reg(REG_SAT_HIGH, sh);
    write_reg(REG_VAL_LOW, vl);
    write_reg(REG_VAL_HIGH, vh);
    write_reg(REG_FRAME_WIDTH, fw);
    write_reg(REG_FRAME_HEIGHT, fh);
  endtask

  function automatic int edgy(input int lo, input int hi);
    case ($urandom_range(0, 3))
      0: return lo;
      1: return hi;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  // Strongly saturated colour near a hue of 60*k degrees.
  function automatic logic [23:0] key_colour(input int k);
    int v;
    logic [7:0] r, g, b;
    v = $urandom_range(200, 240);
    r = 8'($urandom_range(0, 12));
    g = 8'($urandom_range(0, 12));
    b = 8'($urandom_range(0, 12));
    if (k == 0 || k == 1 || k == 5) r = 8'(v - $urandom_range(0, 6));
    if (k >= 1 && k <= 3) g = 8'(v - $urandom_range(0, 6));
    if (k >= 3 && k <= 5) b = 8'(v - $urandom_range(0, 6));
    return {r, g, b};
  endfunction

  initial begin : stimulus
    int k, fw, fh, x0, x1, y0, y1, n, phase, col, line;
    logic [23:0] px;
    phase = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (PROBE_COLOURS[i]) send_pixel(PROBE_COLOURS[i]);

    // The frame is shrunk while the column is well past the new line length.
    wait_drained();
    write_reg(REG_FRAME_WIDTH, 8);
    write_reg(REG_FRAME_HEIGHT, 4);
    repeat (40) send_pixel(24'($urandom()));

    wait_drained();
    set_windows(0, 360, 0, 255, 0, 255, 511, 1);
    repeat (256) send_pixel(24'($urandom()));

    wait_drained();
    set_windows(0, 360, 0, 0, 0, 0, 0, 511);
    repeat (256) send_pixel($urandom_range(0, 1) ? 24'h000000 : 24'($urandom()));

    while (sent < TOTAL_PIXELS) begin
      wait_drained();
      calm = ($urandom_range(0, 3) == 0);
      if (phase % 3 != 1) begin
        k = $urandom_range(0, 5);
        fw = $urandom_range(6, 16);
        fh = $urandom_range(5, 12);
        set_windows((60 * k + 345) % 360, (60 * k + 15) % 360, $urandom_range(100, 200),
                    $urandom_range(0, 1) ? 255 : 250, $urandom_range(40, 150), 255, fw, fh);
        for (int f = 0; f < 3; f++) begin
          x0 = $urandom_range(0, fw / 3);
          x1 = $urandom_range(fw / 2, fw - 1);
          y0 = $urandom_range(0, fh / 3);
          y1 = $urandom_range(fh / 2, fh - 1);
          for (n = 0; n < fw * fh; n++) begin
            if (f == 1 && n == (fw * fh) / 2) wait_drained();
            col = n % fw;
            line = n / fw;
            if (col >= x0 && col <= x1 && line >= y0 && line <= y1)
              px = ($urandom_range(0, 9) != 0) ? key_colour(k) : 24'($urandom());
            else
              px = ($urandom_range(0, 24) == 0) ? key_colour(k) : 24'($urandom());
            send_pixel(px);
          end
        end
      end else begin
        set_windows(edgy(0, 360), edgy(0, 360), edgy(0, 255), edgy(0, 255),
                    edgy(0, 255), edgy(0, 255), edgy(0, 12), edgy(0, 12));
        repeat ($urandom_range(30, 90)) begin
          case ($urandom_range(0, 2))
            0: px = key_colour($urandom_range(0, 5));
            1: px = 24'($urandom()) & {3{($urandom_range(0, 1) ? 8'hFF : 8'h00)}};
            default: px = 24'($urandom());
          endcase
          send_pixel(px);
        end
      end
      phase++;
    end

    calm = 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && open_results == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
